@@ rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types and constants for the sync marker frame deframer
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int WORD_W      = 16;
    localparam int POS_W       = 20;
    localparam int STATUS_W    = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int LEN_SHIFT   = 3;   // length unit is 8 words

    localparam logic [WORD_W-1:0] HEADER_MARKER_RST  = 16'h805A;
    localparam logic [WORD_W-1:0] TRAILER_MARKER_RST = 16'h8069;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_BAD_HEADER  = 2'd1;
    localparam status_t ST_BAD_TRAILER = 2'd2;
    localparam status_t ST_ZERO_LEN    = 2'd3;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_HEADER_MARKER  = 2'd0;
    localparam reg_idx_t REG_TRAILER_MARKER = 2'd1;
    localparam reg_idx_t REG_RESYNC         = 2'd2;

    typedef enum logic [3:0] {
        MODE_HUNT   = 4'b0001,
        MODE_EXPECT = 4'b0010,
        MODE_FRAME  = 4'b0100,
        MODE_HALT   = 4'b1000
    } mode_t;

endpackage

@@ rtl/sync_marker_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_marker_frame_deframer
// byte-swaps a 16-bit word stream, locks on header markers and marks frames
//
// channel   dir   fields
// s_        in    tdata[15:0] raw_word
// m_        out   tdata[15:0] word, tlast last_word, tuser[0] first_word,
//                 tuser[2:1] status
// cfg       in    apb: 0x0 header_marker, 0x4 trailer_marker,
//                 0x8 resync_after_error
//
// one word per cycle; the compare and counter update sit between the input
// port and the result register, so a result appears in the cycle after its
// transfer. the result register frees up in the same cycle it is taken, so
// input is only held off while a result waits on m_tready low.
// reset (synchronous, active low) returns to hunting with default markers.
// ----------------------------------------------------------------------------
module sync_marker_frame_deframer (
    input  logic                         aclk,
    input  logic                         aresetn,
    // raw_word
    input  logic [sfd_pkg::WORD_W-1:0]   s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // word
    output logic [sfd_pkg::WORD_W-1:0]   m_tdata,
    output logic                         m_tlast,
    // [0] first_word, [2:1] status
    output logic [2:0]                   m_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                         pready
);
    import sfd_pkg::*;

    logic [WORD_W-1:0] header_marker_reg;
    logic [WORD_W-1:0] trailer_marker_reg;
    logic              resync_reg;

    mode_t             mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  fw_reg, fw_next;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_first_reg, out_last_reg;
    status_t           out_status_reg;

    logic              emit;
    logic              emit_first, emit_last;
    status_t           emit_status;
    logic              err;

    logic              in_xfer;
    logic [WORD_W-1:0] w;
    logic              hdr_match;
    logic              len_hit;
    logic [POS_W-1:0]  fw_eff;
    logic              at_end;
    reg_idx_t          cfg_idx;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_marker_reg  <= HEADER_MARKER_RST;
            trailer_marker_reg <= TRAILER_MARKER_RST;
            resync_reg         <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (cfg_idx)
                REG_HEADER_MARKER:  header_marker_reg  <= pwdata[WORD_W-1:0];
                REG_TRAILER_MARKER: trailer_marker_reg <= pwdata[WORD_W-1:0];
                REG_RESYNC:         resync_reg         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_HEADER_MARKER:  prdata = CFG_DATA_W'(header_marker_reg);
            REG_TRAILER_MARKER: prdata = CFG_DATA_W'(trailer_marker_reg);
            REG_RESYNC:         prdata = CFG_DATA_W'(resync_reg);
            default:            prdata = '0;
        endcase
    end

    // stream side
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign w         = {s_tdata[7:0], s_tdata[15:8]};
    assign hdr_match = (w == header_marker_reg);
    assign len_hit   = (pos_reg == POS_W'(2));
    // frame length becomes known on word 2 and counts in the same compare
    assign fw_eff    = len_hit ? (POS_W'(w) << LEN_SHIFT) : fw_reg;
    assign at_end    = (fw_eff != '0) &&
                       (({1'b0, pos_reg} + (POS_W+1)'(1)) >= {1'b0, fw_eff});

    always_comb begin
        emit        = 1'b0;
        emit_first  = 1'b0;
        emit_last   = 1'b0;
        emit_status = ST_OK;
        err         = 1'b0;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        fw_next     = fw_reg;
        unique case (mode_reg)
            MODE_HUNT: begin
                if (hdr_match) begin
                    emit       = 1'b1;
                    emit_first = 1'b1;
                    mode_next  = MODE_FRAME;
                    pos_next   = POS_W'(1);
                    fw_next    = '0;
                end
            end
            MODE_EXPECT: begin
                emit = 1'b1;
                if (hdr_match) begin
                    emit_first = 1'b1;
                    mode_next  = MODE_FRAME;
                    pos_next   = POS_W'(1);
                    fw_next    = '0;
                end else begin
                    emit_last   = 1'b1;
                    emit_status = ST_BAD_HEADER;
                    err         = 1'b1;
                end
            end
            MODE_FRAME: begin
                emit = 1'b1;
                priority if (len_hit && (w == '0)) begin
                    emit_last   = 1'b1;
                    emit_status = ST_ZERO_LEN;
                    err         = 1'b1;
                end else if (at_end) begin
                    emit_last = 1'b1;
                    if (w != trailer_marker_reg) begin
                        emit_status = ST_BAD_TRAILER;
                        err         = 1'b1;
                    end else begin
                        mode_next = MODE_EXPECT;
                        pos_next  = '0;
                        fw_next   = '0;
                    end
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                    fw_next  = fw_eff;
                end
            end
            MODE_HALT: ;
            default: begin
                mode_next = MODE_HUNT;
            end
        endcase
        if (err) begin
            mode_next = resync_reg ? MODE_HUNT : MODE_HALT;
            pos_next  = '0;
            fw_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_HUNT;
            pos_reg  <= '0;
            fw_reg   <= '0;
        end else if (in_xfer) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            fw_reg   <= fw_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= in_xfer && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && emit) begin
            out_word_reg   <= w;
            out_first_reg  <= emit_first;
            out_last_reg   <= emit_last;
            out_status_reg <= emit_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_status_reg, out_first_reg};

endmodule

@@ rtl/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// sfd_checker
// port-level checks for the sync marker frame deframer
// ----------------------------------------------------------------------------
module sfd_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sfd_pkg::WORD_W-1:0]   s_tdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [sfd_pkg::WORD_W-1:0]   m_tdata,
    input  logic                         m_tlast,
    input  logic [2:0]                   m_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready
);
    import sfd_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // any error result closes the frame
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:1] != ST_OK) |-> m_tlast)
        else $error("error status without last mark");

    // a header word is never a last word and never an error
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tlast && (m_tuser[2:1] == ST_OK))
        else $error("bad marks on header word");

    // an empty result register always takes input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind sync_marker_frame_deframer sfd_checker u_sfd_checker (.*);
